/* src/u2p_pkg.sv */
// ----------------------------------------------------------------------------
// u2p_pkg
// Shared types, constants and the reverse lookup of the PETSCII table.
// ----------------------------------------------------------------------------
package u2p_pkg;

    localparam logic [7:0] ReplResetCode = 8'd63;
    localparam int unsigned QueueDepth = 2;

    typedef struct packed {
        logic [15:0] code_point;
    } t_cp_word;

    typedef struct packed {
        logic [7:0]  petscii_code;
        logic        was_mapped;
    } t_lookup;

    localparam logic [15:0] PetsciiTable [256] = '{
        16'hE000, 16'hE001, 16'hE002, 16'h0003, 16'hE003, 16'hE004, 16'hE005, 16'hE006,
        16'hE007, 16'hE008, 16'hE009, 16'hE00A, 16'hE00B, 16'h000A, 16'hE00C, 16'hE00D,
        16'hE00E, 16'hE00F, 16'hE010, 16'hE011, 16'h0008, 16'hE012, 16'hE013, 16'hE014,
        16'hE015, 16'hE016, 16'hE017, 16'hE018, 16'hE019, 16'hE01A, 16'hE01B, 16'hE01C,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
        16'h0040, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007A, 16'h005B, 16'h00A3, 16'h005D, 16'h2191, 16'h2190,
        16'h2500, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h253C, 16'hE012, 16'h2502, 16'hE013, 16'hE014,
        16'hE015, 16'hE016, 16'hE017, 16'hE018, 16'hE019, 16'hE01A, 16'hE01B, 16'hE01C,
        16'hE01D, 16'hE01E, 16'hE01F, 16'hE020, 16'hE021, 16'h2028, 16'hE022, 16'hE023,
        16'hE024, 16'hE025, 16'hE026, 16'hE027, 16'hE028, 16'hE029, 16'hE02A, 16'hE02B,
        16'hE02C, 16'hE02D, 16'hE02E, 16'hE02F, 16'hE030, 16'hE031, 16'hE032, 16'hE033,
        16'h00A0, 16'h258C, 16'h2584, 16'h2594, 16'h2581, 16'h258E, 16'h2592, 16'hE034,
        16'hE035, 16'hE036, 16'hE037, 16'h251C, 16'h2597, 16'h2514, 16'h2510, 16'h2582,
        16'h250C, 16'h2534, 16'h252C, 16'h2524, 16'h258E, 16'h258D, 16'hE038, 16'hE039,
        16'hE03A, 16'h2583, 16'h2713, 16'h2596, 16'h259D, 16'h2518, 16'h2598, 16'h259A,
        16'h2500, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h253C, 16'hE03B, 16'h2502, 16'hE03C, 16'hE03D,
        16'h00A0, 16'h258C, 16'h2584, 16'h2594, 16'h2581, 16'h258E, 16'h2592, 16'hE03F,
        16'hE040, 16'hE041, 16'hE042, 16'h251C, 16'h2597, 16'h2514, 16'h2510, 16'h2582,
        16'h250C, 16'h2534, 16'h252C, 16'h2524, 16'h258E, 16'h258D, 16'hE043, 16'hE044,
        16'hE045, 16'h2583, 16'h2713, 16'h2596, 16'h259D, 16'h2518, 16'h2598, 16'hE046
    };

    // lowest matching index; descending scan so the lowest hit wins
    function automatic t_lookup lookup(input logic [15:0] cp, input logic [7:0] repl);
        t_lookup res;
        res.petscii_code = repl;
        res.was_mapped   = 1'b0;
        for (int i = 255; i >= 0; i--) begin
            if (PetsciiTable[i] == cp) begin
                res.petscii_code = 8'(i);
                res.was_mapped   = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

/* src/u2p_front.sv */
// ----------------------------------------------------------------------------
// u2p_front
// Accepts UTF-8 bytes, gathers two- and three-byte sequences, emits code points; other non-ASCII bytes emit zero.
// ----------------------------------------------------------------------------
module u2p_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_byte,
    input  logic                 i_valid,
    output logic                 o_ready,
    output u2p_pkg::t_cp_word    o_word,
    output logic                 o_valid,
    input  logic                 i_ready
);
    logic [1:0]  r_pending, n_pending;
    logic [15:0] r_partial, n_partial;
    logic        emit;

    assign o_ready = i_ready;
    assign o_valid = i_valid && emit;
    assign o_word.code_point = n_partial;

    always_comb begin
        n_pending = r_pending;
        n_partial = r_partial;
        emit      = 1'b0;
        if (r_pending != 2'd0) begin
            n_partial = {r_partial[9:0], i_byte[5:0]};
            n_pending = r_pending - 2'd1;
            emit      = (r_pending == 2'd1);
        end else if (i_byte[7] == 1'b0) begin
            n_partial = {8'd0, i_byte};
            emit      = 1'b1;
        end else if (i_byte[7:5] == 3'b110) begin
            n_partial = {11'd0, i_byte[4:0]};
            n_pending = 2'd1;
        end else if (i_byte[7:4] == 4'b1110) begin
            n_partial = {12'd0, i_byte[3:0]};
            n_pending = 2'd2;
        end else begin
            n_partial = 16'd0;
            emit      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= 16'd0;
        end else if (i_valid && o_ready) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
        end
    end
endmodule

/* src/u2p_queue.sv */
// ----------------------------------------------------------------------------
// u2p_queue
// Two-entry queue of code points between front and back.
// ----------------------------------------------------------------------------
module u2p_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  u2p_pkg::t_cp_word    i_word,
    input  logic                 i_valid,
    output logic                 o_ready,
    output u2p_pkg::t_cp_word    o_word,
    output logic                 o_valid,
    input  logic                 i_ready
);
    u2p_pkg::t_cp_word r_mem [u2p_pkg::QueueDepth];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    logic              push, pop;

    assign o_ready = (r_cnt != 2'(u2p_pkg::QueueDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign o_word  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

/* src/u2p_back.sv */
// ----------------------------------------------------------------------------
// u2p_back
// Reverse table lookup and registered output stage.
// ----------------------------------------------------------------------------
module u2p_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_repl,
    input  u2p_pkg::t_cp_word    i_word,
    input  logic                 i_valid,
    output logic                 o_ready,
    output logic [31:0]          o_tdata,
    output logic                 o_tvalid,
    input  logic                 i_tready
);
    u2p_pkg::t_lookup lk;
    logic [31:0]      r_data;
    logic             r_valid;

    assign lk       = u2p_pkg::lookup(i_word.code_point, i_repl);
    assign o_ready  = !r_valid || i_tready;
    assign o_tdata  = r_data;
    assign o_tvalid = r_valid;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= {7'd0, lk.was_mapped, i_word.code_point, lk.petscii_code};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end
endmodule

/* src/utf8_to_petscii_transcoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_petscii_transcoder
// UTF-8 byte stream to PETSCII transcoder, one byte per cycle while the queue has room.
// ----------------------------------------------------------------------------
// Takes one byte per cycle, set by the front decoder, while the queue has room.
// The word of the byte that completes a sequence is held in the queue stage,
// then in the lookup register; lead bytes of multi-byte sequences give no word.
// The two-entry queue absorbs output stalls; when it is full the input stalls.
module utf8_to_petscii_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  s_axis_tdata,   // [7:0] utf8_byte
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] petscii_code, [23:8] code_point,
                                        // [24] was_mapped
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);
    u2p_pkg::t_cp_word f_word, q_word;
    logic f_valid, f_ready, q_valid, q_ready;
    logic [7:0] r_repl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl <= u2p_pkg::ReplResetCode;
        end else if (i_cfg_we) begin
            r_repl <= i_cfg_wdata;
        end
    end

    u2p_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_byte(s_axis_tdata), .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .o_word(f_word), .o_valid(f_valid), .i_ready(f_ready)
    );

    u2p_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_word(f_word), .i_valid(f_valid), .o_ready(f_ready),
        .o_word(q_word), .o_valid(q_valid), .i_ready(q_ready)
    );

    u2p_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_repl(r_repl),
        .i_word(q_word), .i_valid(q_valid), .o_ready(q_ready),
        .o_tdata(m_axis_tdata), .o_tvalid(m_axis_tvalid), .i_tready(m_axis_tready)
    );
endmodule

/* src/u2p_checker.sv */
// ----------------------------------------------------------------------------
// u2p_checker
// Port-level checks of the transcoder.
// ----------------------------------------------------------------------------
module u2p_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:25] == 7'd0)
        else $error("padding bits set");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    a_zero_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[23:8] == 16'd0 |-> !m_axis_tdata[24])
        else $error("code point zero marked as mapped");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("input word changed under stall");
endmodule

bind utf8_to_petscii_transcoder u2p_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready)
);
